>>> rtl/core/pvrl_pkg.sv
package pvrl_pkg;

	// Register indexes on the configuration port (paddr[3:2])
	localparam logic [1:0] REG_CHECK_MODE  = 2'd0;
	localparam logic [1:0] REG_BAND_TOL    = 2'd1;
	localparam logic [1:0] REG_GENERAL_TOL = 2'd2;

	localparam logic [1:0]  CHECK_MODE_RST  = 2'd0;
	localparam logic [30:0] BAND_TOL_RST    = 31'd66;
	localparam logic [30:0] GENERAL_TOL_RST = 31'd66;

	// Check modes
	localparam logic [1:0] MODE_FULL    = 2'd0;
	localparam logic [1:0] MODE_RELEASE = 2'd1;
	localparam logic [1:0] MODE_LIMIT   = 2'd2;

	// Transition codes
	typedef enum logic [2:0] {
		TR_NONE         = 3'd0,
		TR_HIT_LOWER    = 3'd1,
		TR_HIT_UPPER    = 3'd2,
		TR_RELEASED_UP  = 3'd3,
		TR_RELEASED_LOW = 3'd4
	} trans_t;

	// Input beat
	typedef struct packed {
		logic        [5:0]  pv_slot;
		logic signed [31:0] q_calculated;
		logic signed [31:0] q_load;
		logic signed [31:0] q_lower_limit;
		logic signed [31:0] q_upper_limit;
		logic        [30:0] v_magnitude;
		logic        [30:0] v_setpoint;
		logic signed [31:0] q_scheduled;
	} in_t;

	// Result beat
	typedef struct packed {
		logic        [5:0]  slot_out;
		logic               now_limited;
		logic signed [31:0] q_net_target;
		logic        [2:0]  transition;
	} out_t;

	// Configuration seen by front and back
	typedef struct packed {
		logic [1:0]  mode;
		logic [30:0] band_tol;
		logic [30:0] gen_tol;
	} cfg_t;

	// Classified item handed from front to back
	typedef struct packed {
		logic        [5:0]  slot;
		logic               lo_hit;
		logic               hi_hit;
		logic               rel_up;
		logic               rel_lo;
		logic signed [31:0] hi_tgt;
		logic signed [31:0] lo_tgt;
		logic signed [31:0] q_sched;
	} cls_t;

endpackage

>>> rtl/core/pv_bus_reactive_limit_switch_top.sv
// A beat is classified, stored in the front queue, decided by the back and stored in the result queue.
// One item per cycle while results are popped; each of the two queues holds two beats.
// full only rises when the result side stalls; pready is always high.
// Reset (arst_n low, asynchronous) empties both queues, clears every slot's limited and
// side flags, and sets check_mode 0, band_tolerance 66, general_tolerance 66.
module pv_bus_reactive_limit_switch_top import pvrl_pkg::*; #(
	parameter int MAX_PV_BUSES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// input queue
	input  logic        push,
	output logic        full,
	input  in_t         item,
	// result queue
	output logic        empty,
	input  logic        pop,
	output out_t        result,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [1:0]  mode_q;
	logic [30:0] band_tol_q;
	logic [30:0] gen_tol_q;
	cfg_t        cfg;
	logic        cfg_wr;

	cls_t        cls_in;
	cls_t        cls_out;
	logic [$bits(cls_t)-1:0] cls_raw;
	logic        mid_empty;
	out_t        res;
	logic [$bits(out_t)-1:0] res_raw;
	logic        out_full;
	logic        fire;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= CHECK_MODE_RST;
			band_tol_q <= BAND_TOL_RST;
			gen_tol_q  <= GENERAL_TOL_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_CHECK_MODE:  mode_q     <= pwdata[1:0];
				REG_BAND_TOL:    band_tol_q <= pwdata[30:0];
				REG_GENERAL_TOL: gen_tol_q  <= pwdata[30:0];
				default:         mode_q     <= mode_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_CHECK_MODE:  prdata = {30'd0, mode_q};
			REG_BAND_TOL:    prdata = {1'b0, band_tol_q};
			REG_GENERAL_TOL: prdata = {1'b0, gen_tol_q};
			default:         prdata = 32'd0;
		endcase
	end

	assign cfg.mode     = mode_q;
	assign cfg.band_tol = band_tol_q;
	assign cfg.gen_tol  = gen_tol_q;

	// Front: classify the beat
	pvrl_front u_front (
		.item (item),
		.cfg  (cfg),
		.cls  (cls_in)
	);

	pvrl_fifo #(.W($bits(cls_t))) u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (cls_in),
		.full    (full),
		.rd_en   (fire),
		.rd_data (cls_raw),
		.empty   (mid_empty)
	);

	assign cls_out = cls_t'(cls_raw);
	assign fire    = !mid_empty && !out_full;

	// Back: flag table and decision
	pvrl_back #(.MAX_PV_BUSES(MAX_PV_BUSES)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cls    (cls_out),
		.fire   (fire),
		.res    (res)
	);

	pvrl_fifo #(.W($bits(out_t))) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fire),
		.wr_data (res),
		.full    (out_full),
		.rd_en   (pop),
		.rd_data (res_raw),
		.empty   (empty)
	);

	assign result = out_t'(res_raw);

endmodule

>>> rtl/core/pvrl_fifo.sv
module pvrl_fifo #(
	parameter int W = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	output logic         full,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic         empty
);

	// Two-entry queue: one beat per cycle in and out with no bubble while not full
	logic [W-1:0] mem_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;
	logic         do_wr;
	logic         do_rd;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) wr_ptr_q <= !wr_ptr_q;
			if (do_rd) rd_ptr_q <= !rd_ptr_q;
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

>>> rtl/core/pvrl_front.sv
module pvrl_front import pvrl_pkg::*; (
	input  in_t  item,
	input  cfg_t cfg,
	output cls_t cls
);

	function automatic logic signed [31:0] sat33(input logic signed [32:0] d);
		logic signed [31:0] r;
		if (d[32] != d[31]) r = d[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		else r = d[31:0];
		return r;
	endfunction

	logic [30:0]        tol;
	logic signed [33:0] tol_s;
	logic signed [33:0] gen;
	logic [32:0]        vm;
	logic [32:0]        vs;
	logic [32:0]        tol_u;
	logic signed [32:0] hi_d;
	logic signed [32:0] lo_d;

	// Limit-only mode runs on the general tolerance
	assign tol   = (cfg.mode == MODE_LIMIT) ? cfg.gen_tol : cfg.band_tol;
	assign tol_s = {3'b000, tol};
	assign tol_u = {2'b00, tol};

	// Generation band test, exact in 34 bits
	assign gen = 34'(item.q_calculated) + 34'(item.q_load);

	// Voltage release tests, exact in 33 bits
	assign vm = {2'b00, item.v_magnitude};
	assign vs = {2'b00, item.v_setpoint};

	// Held-limit setpoints, both sides precomputed
	assign hi_d = 33'(item.q_upper_limit) - 33'(item.q_load);
	assign lo_d = 33'(item.q_lower_limit) - 33'(item.q_load);

	always_comb begin
		cls.slot    = item.pv_slot;
		cls.lo_hit  = (gen + tol_s) < 34'(item.q_lower_limit);
		cls.hi_hit  = gen > (34'(item.q_upper_limit) + tol_s);
		cls.rel_up  = vm > (vs + tol_u);
		cls.rel_lo  = (vm + tol_u) < vs;
		cls.hi_tgt  = sat33(hi_d);
		cls.lo_tgt  = sat33(lo_d);
		cls.q_sched = item.q_scheduled;
	end

endmodule

>>> rtl/core/pvrl_back.sv
module pvrl_back import pvrl_pkg::*; #(
	parameter int MAX_PV_BUSES = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  cls_t cls,
	input  logic fire,
	output out_t res
);

	// Only 64 slots are addressable, so the table never exceeds that
	localparam int TBL = (MAX_PV_BUSES < 64) ? MAX_PV_BUSES : 64;
	localparam int IW  = (TBL > 1) ? $clog2(TBL) : 1;

	logic [TBL-1:0] limited_q;
	logic [TBL-1:0] upper_q;
	logic [IW-1:0]  idx;
	logic           in_range;
	logic           lim_cur;
	logic           up_cur;
	logic           lim_nxt;
	logic           up_nxt;
	trans_t         trans;

	assign in_range = (32'(cls.slot) < MAX_PV_BUSES);
	assign idx      = cls.slot[IW-1:0];
	assign lim_cur  = in_range && limited_q[idx];
	assign up_cur   = in_range && upper_q[idx];

	// Limit / release decision for the slot
	always_comb begin
		lim_nxt = lim_cur;
		up_nxt  = up_cur;
		trans   = TR_NONE;
		if (!lim_cur && (cfg.mode == MODE_FULL || cfg.mode == MODE_LIMIT)) begin
			if (cls.lo_hit) begin
				lim_nxt = 1'b1;
				up_nxt  = 1'b0;
				trans   = TR_HIT_LOWER;
			end else if (cls.hi_hit) begin
				lim_nxt = 1'b1;
				up_nxt  = 1'b1;
				trans   = TR_HIT_UPPER;
			end
		end else if (lim_cur && (cfg.mode == MODE_FULL || cfg.mode == MODE_RELEASE)) begin
			if (up_cur) begin
				if (cls.rel_up) begin
					lim_nxt = 1'b0;
					trans   = TR_RELEASED_UP;
				end
			end else begin
				if (cls.rel_lo) begin
					lim_nxt = 1'b0;
					trans   = TR_RELEASED_LOW;
				end
			end
		end
		if (!in_range) begin
			lim_nxt = 1'b0;
			trans   = TR_NONE;
		end
	end

	// Result beat
	always_comb begin
		res.slot_out    = cls.slot;
		res.now_limited = lim_nxt;
		res.transition  = trans;
		if (lim_nxt) res.q_net_target = up_nxt ? cls.hi_tgt : cls.lo_tgt;
		else res.q_net_target = cls.q_sched;
	end

	// Flag table update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limited_q <= '0;
			upper_q   <= '0;
		end else if (fire && in_range) begin
			limited_q[idx] <= lim_nxt;
			upper_q[idx]   <= up_nxt;
		end
	end

endmodule

>>> rtl/core/pvrl_checker.sv
module pvrl_checker import pvrl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic full,
	input logic empty,
	input logic pop,
	input out_t result,
	input logic pready
);

	// Beats accepted but not yet delivered
	logic [3:0] pending_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = push && !full;
	assign out_beat = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 4'd0;
		end else begin
			pending_q <= pending_q + 4'(in_beat) - 4'(out_beat);
		end
	end

	// No result without an accepted item
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> pending_q != 4'd0)
		else $error("result shown with no item pending");

	// An item into an idle block shows its result after passing both queues
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && empty && pending_q == 4'd0 |-> ##2 !empty)
		else $error("result missing after two cycles");

	// Transition code agrees with the limited status
	a_trans_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.transition == TR_NONE)
			|| ((result.transition == TR_HIT_LOWER
				|| result.transition == TR_HIT_UPPER) && result.now_limited)
			|| ((result.transition == TR_RELEASED_UP
				|| result.transition == TR_RELEASED_LOW) && !result.now_limited))
		else $error("transition code inconsistent with now_limited");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind pv_bus_reactive_limit_switch_top pvrl_checker u_pvrl_checker (.*);

>>> sim/tb_pv_bus_reactive_limit_switch_top.sv
`timescale 1ns / 1ps

module tb_pv_bus_reactive_limit_switch_top;
	import pvrl_pkg::*;

	localparam int     PV_SLOTS    = 64;
	localparam int     CYCLE_LIMIT = 500000;
	localparam longint Q_MIN       = -64'sd2147483648;
	localparam longint Q_MAX       = 64'sd2147483647;
	localparam longint V_MAX       = 64'sd2147483647;
	localparam logic [1:0]  MODE_UNUSED = 2'd3;
	localparam logic [1:0]  REG_UNUSED  = 2'd3;
	localparam logic [30:0] TOL_MAX     = 31'h7fffffff;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	in_t         item;
	logic        empty;
	logic        pop;
	out_t        result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	pv_bus_reactive_limit_switch_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.empty   (empty),
		.pop     (pop),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Mirror of the block: per-slot flags and register contents
	logic        slot_limited [PV_SLOTS];
	logic        slot_upper   [PV_SLOTS];
	logic [1:0]  cur_mode;
	logic [30:0] cur_band_tol;
	logic [30:0] cur_gen_tol;

	in_t  bus_checks_todo [$];
	out_t targets_due [$];

	int   mismatches;
	int   cycles;
	bit   beat_taken;
	bit   no_idle;
	bit   hold_req;
	int   send_gap;
	int   stall_left;
	int   hold_left;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic longint clip(longint v, longint lo, longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Limit / release decision for one bus slot; updates the mirrored flags
	function automatic out_t advance_pv_slot(in_t b);
		longint gen, ld, lo, hi, vm, vs, tol, tgt;
		logic   lim, up;
		trans_t tr;
		out_t   r;
		ld  = longint'($signed(b.q_load));
		lo  = longint'($signed(b.q_lower_limit));
		hi  = longint'($signed(b.q_upper_limit));
		gen = longint'($signed(b.q_calculated)) + ld;
		vm  = longint'(b.v_magnitude);
		vs  = longint'(b.v_setpoint);
		tol = (cur_mode == MODE_LIMIT) ? longint'(cur_gen_tol) : longint'(cur_band_tol);
		lim = slot_limited[b.pv_slot];
		up  = slot_upper[b.pv_slot];
		tr  = TR_NONE;
		if (!lim && (cur_mode == MODE_FULL || cur_mode == MODE_LIMIT)) begin
			// lower limit is tested first, so it wins when both are violated
			if (gen < lo - tol) begin
				lim = 1'b1;
				up  = 1'b0;
				tr  = TR_HIT_LOWER;
			end else if (gen > hi + tol) begin
				lim = 1'b1;
				up  = 1'b1;
				tr  = TR_HIT_UPPER;
			end
		end else if (lim && (cur_mode == MODE_FULL || cur_mode == MODE_RELEASE)) begin
			// stored side bit picks the voltage test
			if (up) begin
				if (vm > vs + tol) begin
					lim = 1'b0;
					tr  = TR_RELEASED_UP;
				end
			end else if (vm < vs - tol) begin
				lim = 1'b0;
				tr  = TR_RELEASED_LOW;
			end
		end
		slot_limited[b.pv_slot] = lim;
		slot_upper[b.pv_slot]   = up;
		tgt = lim ? ((up ? hi : lo) - ld) : longint'($signed(b.q_scheduled));
		tgt = clip(tgt, Q_MIN, Q_MAX);
		r.slot_out     = b.pv_slot;
		r.now_limited  = lim;
		r.q_net_target = tgt[31:0];
		r.transition   = tr;
		return r;
	endfunction

	function automatic in_t bus_check(int slot, longint qc, longint ql, longint qlo,
			longint qhi, longint vm, longint vs, longint qs);
		in_t b;
		b.pv_slot       = slot[5:0];
		b.q_calculated  = qc[31:0];
		b.q_load        = ql[31:0];
		b.q_lower_limit = qlo[31:0];
		b.q_upper_limit = qhi[31:0];
		b.v_magnitude   = vm[30:0];
		b.v_setpoint    = vs[30:0];
		b.q_scheduled   = qs[31:0];
		return b;
	endfunction

	// Mostly values placed on the tolerance bounds of a few slots, some raw noise
	function automatic in_t random_bus_check();
		longint tol, lo, hi, ld, gen, vs, vm, nudge;
		if ($urandom_range(0, 3) == 0)
			return bus_check($urandom_range(0, 63), $signed($urandom), $signed($urandom),
				$signed($urandom), $signed($urandom), $urandom, $urandom,
				$signed($urandom));
		tol   = (cur_mode == MODE_LIMIT) ? longint'(cur_gen_tol) : longint'(cur_band_tol);
		nudge = longint'($urandom_range(0, 6)) - 3;
		lo    = longint'($urandom_range(0, 2097152)) - 1048576;
		hi    = lo + longint'($urandom_range(0, 1048576));
		ld    = longint'($urandom_range(0, 1048576)) - 524288;
		case ($urandom_range(0, 2))
			0: gen = lo - tol + nudge;
			1: gen = hi + tol + nudge;
			default: gen = lo + longint'($urandom_range(0, 1048576)) % (hi - lo + 1);
		endcase
		vs = longint'($urandom_range(32768, 131072));
		case ($urandom_range(0, 2))
			0: vm = vs + tol + nudge;
			1: vm = vs - tol + nudge;
			default: vm = vs;
		endcase
		return bus_check($urandom_range(0, 7), clip(gen - ld, Q_MIN, Q_MAX), ld, lo, hi,
			clip(vm, 0, V_MAX), vs, $signed($urandom));
	endfunction

	// Input side: takes beats from the pending queue, with idle bursts
	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (!push || beat_taken) begin
			if (send_gap > 0) begin
				send_gap--;
				push <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 7) == 0) begin
				send_gap = $urandom_range(0, 16);
				push <= 1'b0;
			end else if (bus_checks_todo.size() > 0) begin
				item <= bus_checks_todo[0];
				push <= 1'b1;
			end else begin
				push <= 1'b0;
			end
		end
		beat_taken = 1'b0;
	end

	// Accepted input beat: predict its result
	always @(posedge clk) begin
		if (arst_n && push && !full) begin
			targets_due.push_back(advance_pv_slot(item));
			void'(bus_checks_todo.pop_front());
			beat_taken = 1'b1;
		end
	end

	// Result side: stall bursts and one long hold-off on request
	always @(negedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = 80;
			pop <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			pop <= 1'b0;
		end else if (!no_idle && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 16);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	// Accepted result beat against the oldest prediction
	always @(posedge clk) begin
		out_t want;
		if (arst_n && pop && !empty) begin
			if (targets_due.size() == 0) begin
				$error("result beat for slot %0d with nothing expected", result.slot_out);
				mismatches++;
			end else begin
				want = targets_due.pop_front();
				if (result.slot_out !== want.slot_out) begin
					$error("slot_out: expected %0d, got %0d", want.slot_out, result.slot_out);
					mismatches++;
				end
				if (result.now_limited !== want.now_limited) begin
					$error("now_limited: expected %0d, got %0d", want.now_limited,
						result.now_limited);
					mismatches++;
				end
				if (result.q_net_target !== want.q_net_target) begin
					$error("q_net_target: expected %0d, got %0d", want.q_net_target,
						result.q_net_target);
					mismatches++;
				end
				if (result.transition !== want.transition) begin
					$error("transition: expected %0d, got %0d", want.transition,
						result.transition);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// One register write: setup beat, then access beat
	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		case (idx)
			REG_CHECK_MODE:  cur_mode     = val[1:0];
			REG_BAND_TOL:    cur_band_tol = val[30:0];
			REG_GENERAL_TOL: cur_gen_tol  = val[30:0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Sender holds until every predicted result is back
	task automatic drain_results();
		while (bus_checks_todo.size() > 0 || targets_due.size() > 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic run_phase(logic [1:0] mode, logic [30:0] band, logic [30:0] gen, int count);
		drain_results();
		write_reg(REG_CHECK_MODE, {30'd0, mode});
		// bit 31 of the tolerance words is not stored
		write_reg(REG_BAND_TOL, {1'($urandom_range(0, 1)), band});
		write_reg(REG_GENERAL_TOL, {1'($urandom_range(0, 1)), gen});
		repeat (count) bus_checks_todo.push_back(random_bus_check());
	endtask

	initial begin
		push       = 1'b0;
		item       = '0;
		pop        = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		arst_n     = 1'b0;
		mismatches = 0;
		cycles     = 0;
		beat_taken = 1'b0;
		no_idle    = 1'b0;
		hold_req   = 1'b0;
		send_gap   = 0;
		stall_left = 0;
		hold_left  = 0;
		cur_mode     = CHECK_MODE_RST;
		cur_band_tol = BAND_TOL_RST;
		cur_gen_tol  = GENERAL_TOL_RST;
		for (int i = 0; i < PV_SLOTS; i++) begin
			slot_limited[i] = 1'b0;
			slot_upper[i]   = 1'b0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed checks at reset settings (full check, tolerance 66)
		// hit lower, then released on low voltage
		bus_checks_todo.push_back(bus_check(0, 0, 0, 1000, 2000, 200, 200, 77));
		bus_checks_todo.push_back(bus_check(0, 0, 0, 1000, 2000, 100, 200, 77));
		// hit upper, held right at the voltage bound, then released
		bus_checks_todo.push_back(bus_check(1, 3000, 0, 1000, 2000, 200, 200, -5));
		bus_checks_todo.push_back(bus_check(1, 0, 10, -400, 900, 266, 200, -5));
		bus_checks_todo.push_back(bus_check(1, 0, 10, -400, 900, 267, 200, -5));
		// both limits violated: lower side taken
		bus_checks_todo.push_back(bus_check(2, 0, 0, 5000, -5000, 0, 0, 9));
		// generation exactly on each widened limit stays free
		bus_checks_todo.push_back(bus_check(3, 1000, 0, 1066, 5000, 0, 0, 1));
		bus_checks_todo.push_back(bus_check(3, 1000, 0, -5000, 934, 0, 0, 2));
		// extreme sums, targets saturate
		bus_checks_todo.push_back(bus_check(4, Q_MAX, Q_MAX, Q_MIN, Q_MIN, 0, 0, 0));
		bus_checks_todo.push_back(bus_check(5, Q_MIN, Q_MIN, Q_MAX, Q_MAX, 0, 0, 0));
		// releases at the voltage extremes; slots 63 and 62 stay free
		bus_checks_todo.push_back(bus_check(5, 0, 0, 0, 0, 0, V_MAX, Q_MAX));
		bus_checks_todo.push_back(bus_check(4, 0, 0, 0, 0, V_MAX, 0, Q_MIN));
		bus_checks_todo.push_back(bus_check(63, -1, -1, -1, -1, V_MAX, V_MAX, Q_MIN));
		bus_checks_todo.push_back(bus_check(62, 0, 0, 0, 0, 0, 0, Q_MAX));

		// the unused register index must leave the others alone
		drain_results();
		write_reg(REG_UNUSED, $urandom);
		run_phase(MODE_FULL, 31'd66, 31'd66, 350);
		hold_req = 1'b1;
		run_phase(MODE_RELEASE, 31'd0, 31'd300, 150);
		run_phase(MODE_LIMIT, 31'd1000, TOL_MAX, 100);
		run_phase(MODE_LIMIT, 31'd5, 31'd0, 150);
		run_phase(MODE_UNUSED, 31'd200, 31'd200, 100);
		run_phase(MODE_FULL, TOL_MAX, 31'd7, 100);
		run_phase(MODE_RELEASE, 31'd4096, 31'd1, 150);
		run_phase(MODE_FULL, 31'd0, TOL_MAX, 200);
		drain_results();
		no_idle = 1'b1;
		run_phase(MODE_FULL, 31'd66, 31'd66, 240);
		drain_results();
		repeat (8) @(negedge clk);

		if (mismatches == 0 && targets_due.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

>>> pv_bus_reactive_limit_switch_top.f
rtl/core/pvrl_pkg.sv
rtl/core/pvrl_fifo.sv
rtl/core/pvrl_front.sv
rtl/core/pvrl_back.sv
rtl/core/pv_bus_reactive_limit_switch_top.sv
rtl/core/pvrl_checker.sv
sim/tb_pv_bus_reactive_limit_switch_top.sv
